@@ src/heightmap_triangle_sample_macros.svh @@
// Assertion macros for the checker file of the height sampler.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLE_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hts_pkg.sv @@
package hts_pkg;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_GRID_COLS    = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [1:0] REG_CELL_SPACING = 2'd2;

    localparam logic [8:0]  RST_GRID_COLS    = 9'd256;
    localparam logic [8:0]  RST_GRID_ROWS    = 9'd256;
    localparam logic [30:0] RST_CELL_SPACING = 31'd65536;

    // Item operations.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Datapath widths.
    localparam int IDX_W   = 9;   // grid index, never above 509
    localparam int SPAN_W  = 40;  // (size - 1) * spacing
    localparam int NUM_W   = 42;  // doubled, centered position
    localparam int DIV_W   = 56;  // magnitude of the dividend and the quotient
    localparam int CELL_W  = 57;  // signed cell coordinate, Q41.16
    localparam int DSUM_W  = 58;  // delta sums and weight arguments
    localparam int PROD_W  = 65;  // 33 x 32 signed product
    localparam int ACC_W   = 51;  // base height plus two terms
    localparam int CNT_W   = 6;
    localparam int DIV_STEPS = 56;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SPAN  = 15'b000000000000010,
        S_DIVI  = 15'b000000000000100,
        S_DIV   = 15'b000000000001000,
        S_DFIN  = 15'b000000000010000,
        S_CELL  = 15'b000000000100000,
        S_DELTA = 15'b000000001000000,
        S_WGT   = 15'b000000010000000,
        S_READ  = 15'b000000100000000,
        S_RLAST = 15'b000001000000000,
        S_DIFF  = 15'b000010000000000,
        S_MUL1  = 15'b000100000000000,
        S_MUL2  = 15'b001000000000000,
        S_SUM   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    // Interpolation weights saturate to the symmetric 32-bit range.
    function automatic logic signed [31:0] sat_weight(input logic signed [DSUM_W-1:0] v);
        if (v > 58'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -58'sd2147483647) begin
            return 32'sh80000001;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_height(input logic signed [ACC_W-1:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ src/heightmap_triangle_sample.sv @@
// Terrain height sampler over a stored grid of signed Q16.16 vertex heights.
// Items arrive on i_valid / o_stall with i_op selecting the operation. A write
// item stores i_write_height at (i_write_row, i_write_col) when accepted and
// gives no result; writes outside MAX_ROWS x MAX_COLS are dropped. A query
// item takes (i_pos_x, i_pos_z) and returns one o_sampled_height on
// o_valid / i_stall.
// The query time is set by one shared restoring divider that makes one
// quotient bit per cycle: two 56-step divisions by the cell spacing, plus
// two spans and two interpolation terms on one shared 33 x 32 multiplier and
// four reads through the single read port of the height memory.
// o_stall is high while a query is in work, so a query holds the input channel
// and a write does not.
// A finished result waits in the output register while the receiver stalls;
// the block keeps taking items meanwhile and only holds a later result until
// that register is free.
// Grid size and cell spacing come from the APB registers; the user must write
// them only while the block is idle, which the block does not enforce. Reset
// clears control state and registers; height memory is undefined until written.
module heightmap_triangle_sample #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [7:0]                  i_write_row,
    input  logic [7:0]                  i_write_col,
    input  logic signed [31:0]          i_write_height,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_sampled_height,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hts_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hts_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE = AW'(MAX_COLS);

    // Configuration registers.
    logic [8:0]  r_grid_cols;
    logic [8:0]  r_grid_rows;
    logic [30:0] r_cell_spacing;

    // Sequencer and datapath registers.
    t_state                       r_state;
    t_state                       n_state;
    logic                         r_zpass;
    logic [CNT_W-1:0]             r_cnt;
    logic [1:0]                   r_rcnt;
    logic signed [31:0]           r_px;
    logic signed [31:0]           r_pz;
    logic [SPAN_W-1:0]            r_span;
    logic                         r_neg;
    logic [DIV_W-1:0]             r_dq;
    logic [30:0]                  r_rem;
    logic signed [CELL_W-1:0]     r_cx;
    logic signed [CELL_W-1:0]     r_cz;
    logic [IDX_W-1:0]             r_vc;
    logic [IDX_W-1:0]             r_vr;
    logic signed [CELL_W-1:0]     r_dx;
    logic signed [CELL_W-1:0]     r_dz;
    logic [AW-1:0]                r_abase;
    logic                         r_lower;
    logic signed [31:0]           r_w1;
    logic signed [31:0]           r_w2;
    logic signed [31:0]           r_h [4];
    logic signed [31:0]           r_rdata;
    logic signed [31:0]           r_hbase;
    logic signed [32:0]           r_d1;
    logic signed [32:0]           r_d2;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_out_valid;
    logic signed [31:0]           r_out_height;

    logic [31:0] r_mem [DEPTH];

    // Combinational helpers.
    logic                         in_accept;
    logic                         cfg_write;
    logic [8:0]                   cols_eff;
    logic [8:0]                   rows_eff;
    logic [IDX_W-1:0]             size_m1;
    logic [IDX_W-1:0]             cols_m2;
    logic [IDX_W-1:0]             rows_m2;
    logic [30:0]                  sp_eff;
    logic signed [32:0]           mul_a;
    logic signed [31:0]           mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [NUM_W-1:0]      num2;
    logic [NUM_W-2:0]             num_mag;
    logic [32:0]                  trial;
    logic                         trial_ge;
    logic signed [CELL_W-1:0]     cell_val;
    logic signed [CELL_W-17:0]    cx_floor;
    logic signed [CELL_W-17:0]    cz_floor;
    logic signed [DSUM_W-1:0]     dx_w;
    logic signed [DSUM_W-1:0]     dz_w;
    logic [AW-1:0]                rd_addr;
    logic                         wr_in_grid;
    logic [AW-1:0]                wr_addr;

    assign in_accept = i_valid && !o_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign o_stall   = !i_rst_n || (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_sampled_height = r_out_height;

    // Effective grid size and spacing.
    always_comb begin
        if (r_grid_cols < 9'd2) begin
            cols_eff = 9'd2;
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols_eff = 9'(MAX_COLS);
        end else begin
            cols_eff = r_grid_cols;
        end
        if (r_grid_rows < 9'd2) begin
            rows_eff = 9'd2;
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows_eff = 9'(MAX_ROWS);
        end else begin
            rows_eff = r_grid_rows;
        end
        sp_eff  = (r_cell_spacing == 31'd0) ? 31'd1 : r_cell_spacing;
        cols_m2 = cols_eff - 9'd2;
        rows_m2 = rows_eff - 9'd2;
        size_m1 = r_zpass ? (rows_eff - 9'd1) : (cols_eff - 9'd1);
    end

    // The one multiplier: spans first, then the two interpolation terms.
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = r_d1;
                mul_b = r_w1;
            end
            S_MUL2: begin
                mul_a = r_d2;
                mul_b = r_w2;
            end
            default: begin
                mul_a = $signed({24'd0, size_m1});
                mul_b = $signed({1'b0, sp_eff});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Doubled position relative to the grid corner; Z runs the other way.
    always_comb begin
        if (r_zpass) begin
            num2 = $signed({2'b00, r_span}) - $signed({{9{r_pz[31]}}, r_pz, 1'b0});
        end else begin
            num2 = $signed({2'b00, r_span}) + $signed({{9{r_px[31]}}, r_px, 1'b0});
        end
        num_mag = num2[NUM_W-1] ? (NUM_W-1)'(-num2) : num2[NUM_W-2:0];
    end

    // One restoring division step; the remainder always stays below the spacing.
    assign trial    = {1'b0, r_rem, r_dq[DIV_W-1]} - {2'b00, sp_eff};
    assign trial_ge = !trial[32];

    // Floor of the signed quotient.
    always_comb begin
        if (r_neg) begin
            cell_val = -$signed({1'b0, r_dq}) - $signed(CELL_W'(r_rem != 31'd0));
        end else begin
            cell_val = $signed({1'b0, r_dq});
        end
    end

    assign cx_floor = r_cx[CELL_W-1:16];
    assign cz_floor = r_cz[CELL_W-1:16];
    assign dx_w     = {r_dx[CELL_W-1], r_dx};
    assign dz_w     = {r_dz[CELL_W-1], r_dz};

    // Corner order A, B, C, D follows the read counter.
    assign rd_addr = r_abase + (r_rcnt[1] ? STRIDE : '0) + (r_rcnt[0] ? AW'(1) : '0);

    assign wr_in_grid = (32'(i_write_row) < MAX_ROWS) && (32'(i_write_col) < MAX_COLS);
    assign wr_addr    = AW'(i_write_row) * STRIDE + AW'(i_write_col);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_op == OP_QUERY) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN:  n_state = S_DIVI;
            S_DIVI:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN:  n_state = r_zpass ? S_CELL : S_SPAN;
            S_CELL:  n_state = S_DELTA;
            S_DELTA: n_state = S_WGT;
            S_WGT:   n_state = S_READ;
            S_READ: begin
                if (r_rcnt == 2'd3) begin
                    n_state = S_RLAST;
                end
            end
            S_RLAST: n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_grid_cols    <= RST_GRID_COLS;
            r_grid_rows    <= RST_GRID_ROWS;
            r_cell_spacing <= RST_CELL_SPACING;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_GRID_COLS:    r_grid_cols    <= pwdata[8:0];
                    REG_GRID_ROWS:    r_grid_rows    <= pwdata[8:0];
                    REG_CELL_SPACING: r_cell_spacing <= pwdata[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_COLS:    prdata = {23'd0, r_grid_cols};
            REG_GRID_ROWS:    prdata = {23'd0, r_grid_rows};
            REG_CELL_SPACING: prdata = {1'b0, r_cell_spacing};
            default:          prdata = 32'd0;
        endcase
    end

    // Height memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_op == OP_WRITE && wr_in_grid) begin
            r_mem[wr_addr] <= i_write_height;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px    <= i_pos_x;
                r_pz    <= i_pos_z;
                r_zpass <= 1'b0;
            end
            S_SPAN: begin
                r_span <= mul_p[SPAN_W-1:0];
            end
            S_DIVI: begin
                r_neg <= num2[NUM_W-1];
                r_dq  <= {num_mag, 15'd0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= trial_ge ? trial[30:0] : {r_rem[29:0], r_dq[DIV_W-1]};
                r_dq  <= {r_dq[DIV_W-2:0], trial_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_DFIN: begin
                if (r_zpass) begin
                    r_cz <= cell_val;
                end else begin
                    r_cx    <= cell_val;
                    r_zpass <= 1'b1;
                end
            end
            S_CELL: begin
                if (cx_floor < 0) begin
                    r_vc <= '0;
                end else if (cx_floor > $signed({32'd0, cols_m2})) begin
                    r_vc <= cols_m2;
                end else begin
                    r_vc <= cx_floor[IDX_W-1:0];
                end
                if (cz_floor < 0) begin
                    r_vr <= '0;
                end else if (cz_floor > $signed({32'd0, rows_m2})) begin
                    r_vr <= rows_m2;
                end else begin
                    r_vr <= cz_floor[IDX_W-1:0];
                end
            end
            S_DELTA: begin
                r_dx    <= r_cx - $signed({32'd0, r_vc, 16'd0});
                r_dz    <= r_cz - $signed({32'd0, r_vr, 16'd0});
                r_abase <= AW'(r_vr) * STRIDE + AW'(r_vc);
                r_rcnt  <= 2'd0;
            end
            S_WGT: begin
                r_lower <= (dx_w + dz_w) < 58'sd65536;
                if ((dx_w + dz_w) < 58'sd65536) begin
                    r_w1 <= sat_weight(dx_w);
                    r_w2 <= sat_weight(dz_w);
                end else begin
                    r_w1 <= sat_weight(58'sd65536 - dx_w);
                    r_w2 <= sat_weight(58'sd65536 - dz_w);
                end
            end
            S_READ: begin
                r_rcnt <= r_rcnt + 2'd1;
                if (r_rcnt != 2'd0) begin
                    r_h[0] <= r_h[1];
                    r_h[1] <= r_h[2];
                    r_h[2] <= r_h[3];
                    r_h[3] <= r_rdata;
                end
            end
            S_RLAST: begin
                r_h[0] <= r_h[1];
                r_h[1] <= r_h[2];
                r_h[2] <= r_h[3];
                r_h[3] <= r_rdata;
            end
            S_DIFF: begin
                // Lower triangle ABC hangs off A, upper triangle DCB off D.
                if (r_lower) begin
                    r_hbase <= r_h[0];
                    r_d1    <= 33'(r_h[1]) - 33'(r_h[0]);
                    r_d2    <= 33'(r_h[2]) - 33'(r_h[0]);
                end else begin
                    r_hbase <= r_h[3];
                    r_d1    <= 33'(r_h[2]) - 33'(r_h[3]);
                    r_d2    <= 33'(r_h[1]) - 33'(r_h[3]);
                end
            end
            S_MUL1: begin
                r_prod <= mul_p;
            end
            S_MUL2: begin
                r_prod <= mul_p;
                r_acc  <= ACC_W'(r_hbase) + ACC_W'($signed(r_prod[PROD_W-1:16]));
            end
            S_SUM: begin
                r_acc <= r_acc + ACC_W'($signed(r_prod[PROD_W-1:16]));
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    r_out_height <= sat_height(r_acc);
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/hts_checker.sv @@
`include "heightmap_triangle_sample_macros.svh"

module hts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                i_op,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [31:0]  o_sampled_height,
    input logic                pready
);
    import hts_pkg::*;

    `HTS_ASSERT_NOW(a_pready_high, 1'b1, pready, "APB pready dropped")

    // A query occupies the sequencer, so the input side must stall next.
    `HTS_ASSERT_NEXT(a_query_busy, i_valid && !o_stall && i_op == OP_QUERY, o_stall, "query did not stall input")

    // Writes finish in the accepting cycle.
    `HTS_ASSERT_NEXT(a_write_free, i_valid && !o_stall && i_op == OP_WRITE, !o_stall, "write held the input")

    // A new result only appears at the end of a query that was being worked.
    `HTS_ASSERT_NOW(a_result_origin, $rose(o_valid), $past(o_stall), "result without a query in work")

    `HTS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sampled_height), "stalled result changed")

endmodule

bind heightmap_triangle_sample hts_checker u_hts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_op             (i_op),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sampled_height (o_sampled_height),
    .pready           (pready)
);
